@@ sv/ffea_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and codes for the first-fit extent allocator.
// Used by the interfaces, the free slot scanner and the top level.
package ffea_pkg;

    localparam int MAX_EXTENTS = 64;
    localparam int NUM_POOLS   = 2;
    localparam int PAGE_BYTES  = 4096;

    localparam int ADDR_W   = 48;
    localparam int PAGES_W  = 20;
    localparam int KIND_W   = 3;
    localparam int MODE_W   = 2;
    localparam int STAT_W   = 2;
    localparam int POOL_W   = 1;
    localparam int SLOT_W   = $clog2(MAX_EXTENTS);
    localparam int LINK_W   = SLOT_W + 1;
    localparam int STEP_W   = $clog2(MAX_EXTENTS + 1);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    localparam int SCAN_LANES = 8;
    localparam int SCAN_GRPS  = (MAX_EXTENTS + SCAN_LANES - 1) / SCAN_LANES;
    localparam int SCAN_GRP_W = (SCAN_GRPS > 1) ? $clog2(SCAN_GRPS) : 1;

    localparam logic [LINK_W-1:0] LINK_NIL = LINK_W'(MAX_EXTENTS);
    localparam logic [KIND_W-1:0] KIND_USABLE = KIND_W'(1);

    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] len;
        logic [KIND_W-1:0] kind;
        logic [LINK_W-1:0] link;
    } t_extent;

    localparam int EXT_W = $bits(t_extent);

    typedef struct packed {
        logic              done;
        logic              found;
        logic [SLOT_W-1:0] slot;
    } t_scan_rsp;

endpackage

@@ sv/ffea_in_if.sv @@
`timescale 1ns / 1ps
// Request channel interface of the extent allocator.
// Depends on ffea_pkg for field widths.
interface ffea_in_if;
    import ffea_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [POOL_W-1:0]   pool;
    logic [PAGES_W-1:0]  page_count;
    logic [ADDR_W-1:0]   address;
    logic [ADDR_W-1:0]   size_bytes;
    logic [KIND_W-1:0]   region_type;

    modport source (output valid, mode, pool, page_count, address, size_bytes, region_type,
                    input ready);
    modport sink   (input valid, mode, pool, page_count, address, size_bytes, region_type,
                    output ready);
endinterface

@@ sv/ffea_out_if.sv @@
`timescale 1ns / 1ps
// Result channel interface of the extent allocator.
// Depends on ffea_pkg for field widths.
interface ffea_out_if;
    import ffea_pkg::*;

    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   result_address;
    logic [STAT_W-1:0]   status;

    modport source (output valid, result_address, status, input ready);
    modport sink   (input valid, result_address, status, output ready);
endinterface

@@ sv/ffea_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module ffea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ sv/ffea_slot_scan.sv @@
`timescale 1ns / 1ps
// Finds the lowest free slot, one group of slots per cycle.
// Depends on ffea_pkg.
module ffea_slot_scan (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [ffea_pkg::MAX_EXTENTS-1:0]        i_in_use,
    output ffea_pkg::t_scan_rsp                     o_rsp
);
    import ffea_pkg::*;

    logic                              r_busy;
    logic                              n_busy;
    logic [SCAN_GRP_W-1:0]             r_grp;
    logic [SCAN_GRP_W-1:0]             n_grp;
    logic [SCAN_GRPS*SCAN_LANES-1:0]   w_free;
    logic [SCAN_LANES-1:0]             w_lanes;
    logic                              w_hit;
    logic [$clog2(SCAN_LANES)-1:0]     w_lane;
    logic                              w_last;

    always_comb begin
        w_free = '0;
        w_free[MAX_EXTENTS-1:0] = ~i_in_use;
        w_lanes = w_free[r_grp*SCAN_LANES +: SCAN_LANES];
        w_hit = 1'b0;
        w_lane = '0;
        for (int b = SCAN_LANES - 1; b >= 0; b--) begin
            if (w_lanes[b]) begin
                w_hit = 1'b1;
                w_lane = ($clog2(SCAN_LANES))'(b);
            end
        end
        w_last = (int'(r_grp) == SCAN_GRPS - 1);
        o_rsp.done  = r_busy && (w_hit || w_last);
        o_rsp.found = r_busy && w_hit;
        o_rsp.slot  = SLOT_W'(int'(r_grp) * SCAN_LANES + int'(w_lane));
        n_busy = r_busy;
        n_grp  = r_grp;
        if (i_start) begin
            n_busy = 1'b1;
            n_grp  = '0;
        end else if (r_busy) begin
            if (w_hit || w_last) begin
                n_busy = 1'b0;
            end else begin
                n_grp = r_grp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_grp  <= '0;
        end else begin
            r_busy <= n_busy;
            r_grp  <= n_grp;
        end
    end
endmodule

@@ sv/first_fit_extent_allocator_unit.sv @@
`timescale 1ns / 1ps
// Top level of the first-fit extent allocator: request sequencer, slot table, pool heads.
// Depends on ffea_pkg, ffea_in_if, ffea_out_if, ffea_ram and ffea_slot_scan.
//
// Usage: requests arrive on i_req (allocate pages, free region, load map extent) and
// each yields exactly one item on o_rsp carrying result_address and status.
// The request is accepted only while the sequencer is idle; it then walks the pool's
// extent list in the slot table RAM, one extent at a time (read, then check and
// write back). A walk covers at most MAX_EXTENTS extents. A free or load that needs a
// new slot adds a scan of the slot bitmap, one group of eight slots a cycle, and
// load adds a tail link update (read, then write of the old tail's link).
// The result sits in an output register: the next request is taken while it waits.
// If the receiver still holds the previous result when a new one is ready, the
// sequencer waits in its final state until the output register drains.
// After reset all slots are free and both pools are empty; the slot table contents
// themselves are not cleared, only the in-use bitmap and pool heads and tails.
module first_fit_extent_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffea_in_if.sink     i_req,
    ffea_out_if.source  o_rsp
);
    import ffea_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RD     = 8'b0000_0010,
        S_CHK    = 8'b0000_0100,
        S_SHRINK = 8'b0000_1000,
        S_GRAB   = 8'b0001_0000,
        S_LDRD   = 8'b0010_0000,
        S_LDWR   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state                  r_state, n_state;
    logic [MODE_W-1:0]       r_mode, n_mode;
    logic [POOL_W-1:0]       r_pool, n_pool;
    logic [ADDR_W-1:0]       r_need, n_need;
    logic [ADDR_W-1:0]       r_addr, n_addr;
    logic [ADDR_W-1:0]       r_size, n_size;
    logic [ADDR_W-1:0]       r_end, n_end;
    logic [KIND_W-1:0]       r_kind, n_kind;
    logic [LINK_W-1:0]       r_cur, n_cur;
    logic [LINK_W-1:0]       r_prev, n_prev;
    t_extent                 r_prev_ext, n_prev_ext;
    logic [STEP_W-1:0]       r_steps, n_steps;
    logic [SLOT_W-1:0]       r_slot, n_slot;
    logic [ADDR_W-1:0]       r_base, n_base;
    logic [ADDR_W-1:0]       r_len, n_len;
    logic [ADDR_W-1:0]       r_res, n_res;
    logic [STAT_W-1:0]       r_stat, n_stat;
    logic [MAX_EXTENTS-1:0]  r_in_use, n_in_use;
    logic [LINK_W-1:0]       r_first [NUM_POOLS];
    logic [LINK_W-1:0]       n_first [NUM_POOLS];
    logic [LINK_W-1:0]       r_last [NUM_POOLS];
    logic [LINK_W-1:0]       n_last [NUM_POOLS];
    logic                    r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]       r_out_addr, n_out_addr;
    logic [STAT_W-1:0]       r_out_stat, n_out_stat;

    logic                    w_we;
    logic [SLOT_W-1:0]       w_waddr;
    t_extent                 w_wdata;
    logic [EXT_W-1:0]        w_rdata;
    t_extent                 w_ext;
    logic                    w_scan_start;
    t_scan_rsp               w_scan;
    logic [LINK_W-1:0]       w_next;
    logic                    w_accept;
    logic                    w_pool_ok;

    ffea_ram #(
        .WIDTH (EXT_W),
        .DEPTH (MAX_EXTENTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_cur[SLOT_W-1:0]),
        .o_rdata (w_rdata)
    );

    ffea_slot_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_scan_start),
        .i_in_use (r_in_use),
        .o_rsp    (w_scan)
    );

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.result_address = r_out_addr;
    assign o_rsp.status         = r_out_stat;
    assign w_accept             = i_req.valid && i_req.ready;
    assign w_ext                = t_extent'(w_rdata);
    assign w_pool_ok            = (int'(i_req.pool) < NUM_POOLS);

    // Successor of the extent just read; a link to a free slot ends the list.
    assign w_next = ((int'(w_ext.link) < MAX_EXTENTS) && r_in_use[w_ext.link[SLOT_W-1:0]])
                    ? w_ext.link : LINK_NIL;

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_pool      = r_pool;
        n_need      = r_need;
        n_addr      = r_addr;
        n_size      = r_size;
        n_end       = r_end;
        n_kind      = r_kind;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_prev_ext  = r_prev_ext;
        n_steps     = r_steps;
        n_slot      = r_slot;
        n_base      = r_base;
        n_len       = r_len;
        n_res       = r_res;
        n_stat      = r_stat;
        n_in_use    = r_in_use;
        n_first     = r_first;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out_addr  = r_out_addr;
        n_out_stat  = r_out_stat;
        w_we         = 1'b0;
        w_waddr      = r_cur[SLOT_W-1:0];
        w_wdata      = w_ext;
        w_scan_start = 1'b0;

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_mode  = i_req.mode;
                    n_pool  = i_req.pool;
                    n_need  = ADDR_W'(i_req.page_count) << PAGE_SHIFT;
                    n_addr  = i_req.address;
                    n_size  = i_req.size_bytes;
                    n_end   = i_req.address + i_req.size_bytes;
                    n_kind  = i_req.region_type;
                    n_prev  = LINK_NIL;
                    n_steps = '0;
                    n_res   = '0;
                    n_stat  = ST_OK;
                    n_cur   = LINK_NIL;
                    if (w_pool_ok) begin
                        n_cur = r_first[i_req.pool];
                    end
                    if (!w_pool_ok && i_req.mode != MODE_NOP) begin
                        n_stat  = ST_NOFIT;
                        n_state = S_DONE;
                    end else if (i_req.mode == MODE_ALLOC || i_req.mode == MODE_FREE) begin
                        n_state = S_RD;
                    end else if (i_req.mode == MODE_LOAD && i_req.address != '0) begin
                        w_scan_start = 1'b1;
                        n_state      = S_GRAB;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RD: begin
                if (int'(r_cur) >= MAX_EXTENTS || int'(r_steps) >= MAX_EXTENTS) begin
                    if (r_mode == MODE_ALLOC) begin
                        n_stat  = ST_NOFIT;
                        n_state = S_DONE;
                    end else begin
                        w_scan_start = 1'b1;
                        n_state      = S_GRAB;
                    end
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_mode == MODE_ALLOC) begin
                    if (w_ext.len >= r_need && w_ext.kind == KIND_USABLE) begin
                        if (w_ext.len == r_need) begin
                            if (r_prev == LINK_NIL) begin
                                n_first[r_pool] = w_next;
                            end else begin
                                w_we         = 1'b1;
                                w_waddr      = r_prev[SLOT_W-1:0];
                                w_wdata      = r_prev_ext;
                                w_wdata.link = w_next;
                            end
                            if (r_last[r_pool] == r_cur) begin
                                n_last[r_pool] = r_prev;
                            end
                            n_in_use[r_cur[SLOT_W-1:0]] = 1'b0;
                            n_res   = w_ext.base;
                            n_state = S_DONE;
                        end else begin
                            w_we        = 1'b1;
                            w_wdata.len = w_ext.len - r_need;
                            n_len       = w_ext.len - r_need;
                            n_base      = w_ext.base;
                            n_state     = S_SHRINK;
                        end
                    end else begin
                        n_prev     = r_cur;
                        n_prev_ext = w_ext;
                        n_cur      = w_next;
                        n_steps    = r_steps + 1'b1;
                        n_state    = S_RD;
                    end
                end else begin
                    if (w_ext.base + w_ext.len == r_addr) begin
                        w_we        = 1'b1;
                        w_wdata.len = w_ext.len + r_size;
                        n_state     = S_DONE;
                    end else if (r_end == w_ext.base) begin
                        w_we         = 1'b1;
                        w_wdata.len  = w_ext.len + r_size;
                        w_wdata.base = r_addr;
                        n_state      = S_DONE;
                    end else begin
                        n_cur   = w_next;
                        n_steps = r_steps + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_SHRINK: begin
                n_res   = r_base + r_len;
                n_state = S_DONE;
            end
            S_GRAB: begin
                if (w_scan.done) begin
                    if (!w_scan.found) begin
                        n_stat  = ST_FULL;
                        n_state = S_DONE;
                    end else begin
                        n_in_use[w_scan.slot] = 1'b1;
                        w_we         = 1'b1;
                        w_waddr      = w_scan.slot;
                        w_wdata.base = r_addr;
                        w_wdata.len  = r_size;
                        n_slot       = w_scan.slot;
                        n_state      = S_DONE;
                        if (r_mode == MODE_FREE) begin
                            w_wdata.kind = KIND_USABLE;
                            w_wdata.link = r_first[r_pool];
                            if (int'(r_first[r_pool]) >= MAX_EXTENTS) begin
                                n_last[r_pool] = LINK_W'(w_scan.slot);
                            end
                            n_first[r_pool] = LINK_W'(w_scan.slot);
                        end else begin
                            w_wdata.kind = r_kind;
                            w_wdata.link = LINK_NIL;
                            n_last[r_pool] = LINK_W'(w_scan.slot);
                            if (int'(r_first[r_pool]) >= MAX_EXTENTS ||
                                int'(r_last[r_pool]) >= MAX_EXTENTS) begin
                                n_first[r_pool] = LINK_W'(w_scan.slot);
                            end else begin
                                n_cur   = r_last[r_pool];
                                n_state = S_LDRD;
                            end
                        end
                    end
                end
            end
            S_LDRD: begin
                n_state = S_LDWR;
            end
            S_LDWR: begin
                w_we         = 1'b1;
                w_wdata.link = LINK_W'(r_slot);
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_addr  = r_res;
                    n_out_stat  = r_stat;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_use    <= '0;
            r_out_valid <= 1'b0;
            for (int p = 0; p < NUM_POOLS; p++) begin
                r_first[p] <= LINK_NIL;
                r_last[p]  <= LINK_NIL;
            end
        end else begin
            r_state     <= n_state;
            r_in_use    <= n_in_use;
            r_out_valid <= n_out_valid;
            r_first     <= n_first;
            r_last      <= n_last;
        end
        r_mode     <= n_mode;
        r_pool     <= n_pool;
        r_need     <= n_need;
        r_addr     <= n_addr;
        r_size     <= n_size;
        r_end      <= n_end;
        r_kind     <= n_kind;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_prev_ext <= n_prev_ext;
        r_steps    <= n_steps;
        r_slot     <= n_slot;
        r_base     <= n_base;
        r_len      <= n_len;
        r_res      <= n_res;
        r_stat     <= n_stat;
        r_out_addr <= n_out_addr;
        r_out_stat <= n_out_stat;
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_req.ready)
        else $error("request taken while a previous item was in progress");

    a_head_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_first[0]) < MAX_EXTENTS) |-> r_in_use[r_first[0][SLOT_W-1:0]])
        else $error("pool head points at a free slot");

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_steps) <= MAX_EXTENTS)
        else $error("list walk ran past the table size");

    a_scan_only_in_grab: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan.done |-> (r_state == S_GRAB))
        else $error("slot scan finished outside of a slot grab");

    a_out_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result item appeared without a finished request");
endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for first_fit_extent_allocator_unit: random and directed requests
// against an extent-list predictor held in a small scoreboard class.
// Depends on ffea_pkg, ffea_in_if, ffea_out_if and the allocator RTL.
module tb_top;
    import ffea_pkg::*;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [STAT_W-1:0] stat;
    } t_outcome;

    class extent_scoreboard;
        logic [ADDR_W-1:0] base [MAX_EXTENTS];
        logic [ADDR_W-1:0] len [MAX_EXTENTS];
        logic [KIND_W-1:0] kind [MAX_EXTENTS];
        int link [MAX_EXTENTS];
        bit used [MAX_EXTENTS];
        int first [NUM_POOLS];
        int last [NUM_POOLS];
        t_outcome pending [$];
        int errors;

        function new();
            for (int i = 0; i < MAX_EXTENTS; i++) begin
                used[i] = 0;
                link[i] = MAX_EXTENTS;
            end
            for (int p = 0; p < NUM_POOLS; p++) begin
                first[p] = MAX_EXTENTS;
                last[p] = MAX_EXTENTS;
            end
            errors = 0;
        endfunction

        function int grab();
            for (int i = 0; i < MAX_EXTENTS; i++) begin
                if (!used[i]) begin
                    used[i] = 1;
                    return i;
                end
            end
            return MAX_EXTENTS;
        endfunction

        function int next_of(int s);
            int n;
            n = link[s];
            return (n < MAX_EXTENTS && used[n]) ? n : MAX_EXTENTS;
        endfunction

        function int live_count();
            int c;
            c = 0;
            foreach (used[i]) c += used[i];
            return c;
        endfunction

        function void note_request(logic [MODE_W-1:0] mode, int p, logic [PAGES_W-1:0] pages,
                                   logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] size,
                                   logic [KIND_W-1:0] k);
            t_outcome o;
            logic [ADDR_W-1:0] need;
            int cur, prv, steps, s;
            bit done;
            o.addr = '0;
            o.stat = ST_OK;
            done = 0;
            if (mode == MODE_ALLOC) begin
                need = ADDR_W'({28'd0, pages} * PAGE_BYTES);
                cur = first[p];
                prv = MAX_EXTENTS;
                steps = 0;
                o.stat = ST_NOFIT;
                while (!done && cur < MAX_EXTENTS && steps < MAX_EXTENTS) begin
                    if (len[cur] >= need && kind[cur] == KIND_USABLE) begin
                        if (len[cur] == need) begin
                            if (prv == MAX_EXTENTS) first[p] = next_of(cur);
                            else link[prv] = next_of(cur);
                            if (last[p] == cur) last[p] = prv;
                            used[cur] = 0;
                            o.addr = base[cur];
                        end else begin
                            len[cur] = len[cur] - need;
                            o.addr = base[cur] + len[cur];
                        end
                        o.stat = ST_OK;
                        done = 1;
                    end else begin
                        prv = cur;
                        cur = next_of(cur);
                        steps++;
                    end
                end
            end else if (mode == MODE_FREE) begin
                cur = first[p];
                steps = 0;
                while (!done && cur < MAX_EXTENTS && steps < MAX_EXTENTS) begin
                    if (ADDR_W'(base[cur] + len[cur]) == addr) begin
                        len[cur] = len[cur] + size;
                        done = 1;
                    end else if (ADDR_W'(addr + size) == base[cur]) begin
                        len[cur] = len[cur] + size;
                        base[cur] = addr;
                        done = 1;
                    end else begin
                        cur = next_of(cur);
                        steps++;
                    end
                end
                if (!done) begin
                    s = grab();
                    if (s == MAX_EXTENTS) begin
                        o.stat = ST_FULL;
                    end else begin
                        base[s] = addr;
                        len[s] = size;
                        kind[s] = KIND_USABLE;
                        link[s] = first[p];
                        if (first[p] >= MAX_EXTENTS) last[p] = s;
                        first[p] = s;
                    end
                end
            end else if (mode == MODE_LOAD && addr != 0) begin
                s = grab();
                if (s == MAX_EXTENTS) begin
                    o.stat = ST_FULL;
                end else begin
                    base[s] = addr;
                    len[s] = size;
                    kind[s] = k;
                    link[s] = MAX_EXTENTS;
                    if (first[p] >= MAX_EXTENTS || last[p] >= MAX_EXTENTS) first[p] = s;
                    else link[last[p]] = s;
                    last[p] = s;
                end
            end
            pending.push_back(o);
        endfunction

        function void check_result(logic [ADDR_W-1:0] addr, logic [STAT_W-1:0] stat);
            t_outcome o;
            if (pending.size() == 0) begin
                report_error($sformatf("unexpected result addr=%h status=%0d", addr, stat));
                return;
            end
            o = pending.pop_front();
            if (addr !== o.addr)
                report_error($sformatf("result_address %h, expected %h", addr, o.addr));
            if (stat !== o.stat)
                report_error($sformatf("status %0d, expected %0d", stat, o.stat));
        endfunction

        function void report_error(string msg);
            errors++;
            $display("ERROR at %0t: %s", $time, msg);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    longint cycles = 0;
    bit rx_stall_mode = 0;
    extent_scoreboard sb;

    ffea_in_if  req_if();
    ffea_out_if rsp_if();

    first_fit_extent_allocator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        req_if.valid = 1'b0;
        req_if.mode = MODE_ALLOC;
        req_if.pool = '0;
        req_if.page_count = '0;
        req_if.address = '0;
        req_if.size_bytes = '0;
        req_if.region_type = '0;
        rsp_if.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.result_address, rsp_if.status);
        if (rx_stall_mode) rsp_if.ready <= ($urandom_range(0, 3) == 0);
        else rsp_if.ready <= ($urandom_range(0, 9) != 0);
    end

    always @(posedge i_clk) begin
        if (cycles % 2000 == 0) rx_stall_mode <= $urandom_range(0, 1);
    end

    int burst_left = 0;

    task automatic send(logic [MODE_W-1:0] mode, logic [POOL_W-1:0] pool,
                        logic [PAGES_W-1:0] pages, logic [ADDR_W-1:0] addr,
                        logic [ADDR_W-1:0] size, logic [KIND_W-1:0] k);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 200);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        req_if.valid <= 1'b1;
        req_if.mode <= mode;
        req_if.pool <= pool;
        req_if.page_count <= pages;
        req_if.address <= addr;
        req_if.size_bytes <= size;
        req_if.region_type <= k;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
        sb.note_request(mode, pool, pages, addr, size, k);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        req_if.valid <= 1'b0;
        while (sb.pending.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (300) @(posedge i_clk);
    endtask

    function automatic logic [ADDR_W-1:0] rand_addr();
        case ($urandom_range(0, 3))
            0: return ADDR_W'({$urandom(), $urandom()});
            1: return ADDR_W'({$urandom_range(1, 4096), 12'd0});
            2: return '1;
            default: return ADDR_W'({$urandom_range(0, 15), 12'd0});
        endcase
    endfunction

    task automatic run_random(int n);
        int p, pick, cur;
        logic [ADDR_W-1:0] a, s;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(0, 1);
            pick = $urandom_range(0, 99);
            if (sb.live_count() > 56 && pick < 60) pick = 60;
            if (pick < 15) begin
                a = rand_addr();
                s = ADDR_W'({$urandom_range(0, 64), 12'd0});
                if ($urandom_range(0, 9) == 0) s = ADDR_W'({$urandom(), $urandom()});
                send(MODE_LOAD, POOL_W'(p), '0, a, s, ($urandom_range(0, 2) == 0) ?
                     KIND_W'($urandom_range(0, 7)) : KIND_USABLE);
            end else if (pick < 35) begin
                cur = sb.first[p];
                if (cur < MAX_EXTENTS && $urandom_range(0, 1)) begin
                    s = ADDR_W'({$urandom_range(0, 8), 12'd0});
                    a = $urandom_range(0, 1) ? ADDR_W'(sb.base[cur] + sb.len[cur])
                                             : ADDR_W'(sb.base[cur] - s);
                end else begin
                    a = rand_addr();
                    s = ADDR_W'({$urandom_range(0, 16), 12'd0});
                end
                send(MODE_FREE, POOL_W'(p), '0, a, s, KIND_W'($urandom_range(0, 7)));
            end else if (pick < 95) begin
                send(MODE_ALLOC, POOL_W'(p), ($urandom_range(0, 19) == 0) ?
                     PAGES_W'($urandom()) : PAGES_W'($urandom_range(0, 20)),
                     ADDR_W'({$urandom(), $urandom()}), ADDR_W'({$urandom(), $urandom()}),
                     KIND_W'($urandom_range(0, 7)));
            end else begin
                send(MODE_NOP, POOL_W'(p), PAGES_W'($urandom()),
                     ADDR_W'({$urandom(), $urandom()}), ADDR_W'({$urandom(), $urandom()}),
                     KIND_W'($urandom_range(0, 7)));
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(MODE_ALLOC, 1'b0, 20'd1, '0, '0, '0);
        send(MODE_LOAD, 1'b0, '0, '0, 48'h10000, KIND_USABLE);
        send(MODE_LOAD, 1'b0, '0, 48'h100000, 48'h10000, KIND_USABLE);
        send(MODE_LOAD, 1'b0, '0, 48'h200000, 48'h10000, 3'd2);
        send(MODE_LOAD, 1'b1, '0, '1, '1, 3'd7);
        send(MODE_LOAD, 1'b1, '0, 48'h400000, 48'h0, KIND_USABLE);
        send(MODE_ALLOC, 1'b1, 20'd0, '0, '0, '0);
        send(MODE_ALLOC, 1'b1, 20'd0, '0, '0, '0);
        send(MODE_ALLOC, 1'b0, 20'd1, '0, '0, '0);
        send(MODE_ALLOC, 1'b0, 20'd15, '0, '0, '0);
        send(MODE_ALLOC, 1'b0, 20'hFFFFF, '1, '1, '0);
        send(MODE_FREE, 1'b0, '0, 48'h100000, 48'h1000, '0);
        send(MODE_FREE, 1'b0, '0, 48'h0FF000, 48'h1000, '0);
        send(MODE_FREE, 1'b0, '0, 48'h800000, 48'h2000, '0);
        send(MODE_FREE, 1'b1, '0, '1, 48'h1, '0);
        send(MODE_NOP, 1'b1, '1, '1, '1, '1);
        send(MODE_ALLOC, 1'b0, 20'd0, '0, '0, '0);
        for (int i = 0; i < 66; i++)
            send(MODE_LOAD, POOL_W'(i % 2), '0, ADDR_W'({i + 1, 24'd0}), 48'h3000,
                 KIND_USABLE);
        send(MODE_FREE, 1'b1, '0, 48'h7000_0000_0000, 48'h1000, '0);
        drain();

        run_random(700);
        drain();
        for (int i = 0; i < 80; i++) send(MODE_ALLOC, POOL_W'(i % 2), 20'd0, '0, '0, '0);
        for (int i = 0; i < 40; i++) send(MODE_ALLOC, POOL_W'(i % 2), 20'd3, '0, '0, '0);
        run_random(800);

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

@@ files.f @@
sv/ffea_pkg.sv
sv/ffea_in_if.sv
sv/ffea_out_if.sv
sv/ffea_ram.sv
sv/ffea_slot_scan.sv
sv/first_fit_extent_allocator_unit.sv
bench/tb_top.sv
